>>> rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// shared types and constants of the postfix expression evaluator
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int STEP_W      = $clog2(WORD_W);

  // ascii codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_DIVZERO   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_EXEC,
    S_DIV,
    S_WB,
    S_EMIT
  } state_t;

  // one port cycle on the stack memory
  typedef struct packed {
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
  } mem_req_t;

endpackage

>>> rtl/pfe_stack_mem.sv
// ----------------------------------------------------------------------------
// pfe_stack_mem
// operand stack storage, one write and one registered read port
// ----------------------------------------------------------------------------
module pfe_stack_mem (
  input  logic                       clk,
  input  pfe_pkg::mem_req_t          req,
  output logic [pfe_pkg::WORD_W-1:0] rd_data
);

  logic [pfe_pkg::WORD_W-1:0] mem [pfe_pkg::STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

>>> rtl/pfe_divider.sv
// ----------------------------------------------------------------------------
// pfe_divider
// signed 32-bit division truncated toward zero, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pfe_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pfe_pkg::WORD_W-1:0] dividend,
  input  logic [pfe_pkg::WORD_W-1:0] divisor,
  output logic                       done,
  output logic [pfe_pkg::WORD_W-1:0] quotient
);

  logic                        busy;
  logic [pfe_pkg::STEP_W-1:0]  step;
  logic [pfe_pkg::WORD_W-1:0]  rem;
  logic [pfe_pkg::WORD_W-1:0]  quo;
  logic [pfe_pkg::WORD_W-1:0]  mag_b;
  logic                        neg;
  logic [pfe_pkg::WORD_W+1:0]  trial;

  // shift in the next dividend bit and try the subtract
  assign trial = {1'b0, rem, quo[pfe_pkg::WORD_W-1]} - {2'b00, mag_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == pfe_pkg::STEP_W'(pfe_pkg::WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= dividend[pfe_pkg::WORD_W-1] ^ divisor[pfe_pkg::WORD_W-1];
      quo   <= dividend[pfe_pkg::WORD_W-1] ? (-dividend) : dividend;
      mag_b <= divisor[pfe_pkg::WORD_W-1] ? (-divisor) : divisor;
      rem   <= '0;
    end else if (busy) begin
      if (!trial[pfe_pkg::WORD_W+1]) begin
        rem <= trial[pfe_pkg::WORD_W-1:0];
        quo <= {quo[pfe_pkg::WORD_W-2:0], 1'b1};
      end else begin
        rem <= {rem[pfe_pkg::WORD_W-2:0], quo[pfe_pkg::WORD_W-1]};
        quo <= {quo[pfe_pkg::WORD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (-quo) : quo;

endmodule

>>> rtl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// postfix expression evaluation over a memory-based operand stack
// ----------------------------------------------------------------------------
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------
//   input   | in_valid / in_stall | symbol[7:0], last
//   output  | out_valid/out_stall | value[31:0] signed, status[2:0]
//
// a digit's push is written in the transfer cycle
// an operator runs two stack memory reads, execute, write back
// a divide adds a wait on the bit-serial divider before the write back
// a result moves to the output register from emit once it is free, an error result too
// rst is synchronous; stack contents are not cleared, only count and flags
// out_stall holds a finished result; items are taken only in idle, and a result
// that finds the output register still occupied waits in emit and stalls the input
//
module postfix_expression_evaluator (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        symbol,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [31:0] value,
  output logic [2:0]        status
);

  pfe_pkg::state_t state, state_next;

  // control state
  logic [pfe_pkg::CNT_W-1:0]  count, count_next;
  logic                       discarding, discarding_next;
  logic                       out_valid_next;

  // item and operand registers
  logic [7:0]                 sym_q;
  logic                       last_q;
  logic [pfe_pkg::WORD_W-1:0] opb;
  logic [pfe_pkg::WORD_W-1:0] res_value, res_value_next;
  logic [2:0]                 res_status, res_status_next;

  pfe_pkg::mem_req_t          mem_req;
  logic [pfe_pkg::WORD_W-1:0] rd_data;

  logic                       div_start;
  logic                       div_done;
  logic [pfe_pkg::WORD_W-1:0] div_quotient;

  // decode of the arriving item
  logic                       accept;
  logic                       is_digit;
  logic                       is_op;
  logic [7:0]                 digit_val;
  logic                       stack_full;
  logic                       stack_short;
  logic                       out_free;

  assign in_stall    = (state != pfe_pkg::S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign is_digit    = (symbol >= pfe_pkg::CH_ZERO) && (symbol <= pfe_pkg::CH_NINE);
  assign is_op       = (symbol == pfe_pkg::CH_PLUS) || (symbol == pfe_pkg::CH_MINUS) ||
                       (symbol == pfe_pkg::CH_STAR) || (symbol == pfe_pkg::CH_SLASH);
  assign digit_val   = symbol - pfe_pkg::CH_ZERO;
  assign stack_full  = (count >= pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH));
  assign stack_short = (count < pfe_pkg::CNT_W'(2));
  assign out_free    = !out_valid || !out_stall;

  pfe_stack_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  pfe_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (opb),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfe_pkg::S_IDLE: begin
        if (accept && !discarding) begin
          if (is_digit) begin
            if (stack_full || last) begin
              state_next = pfe_pkg::S_EMIT;
            end
          end else if (stack_short || !is_op) begin
            state_next = pfe_pkg::S_EMIT;
          end else begin
            state_next = pfe_pkg::S_RD_A;
          end
        end
      end
      pfe_pkg::S_RD_A: state_next = pfe_pkg::S_EXEC;
      pfe_pkg::S_EXEC: begin
        if (sym_q == pfe_pkg::CH_SLASH) begin
          state_next = (opb == '0) ? pfe_pkg::S_EMIT : pfe_pkg::S_DIV;
        end else begin
          state_next = pfe_pkg::S_WB;
        end
      end
      pfe_pkg::S_DIV: begin
        if (div_done) begin
          state_next = pfe_pkg::S_WB;
        end
      end
      pfe_pkg::S_WB:   state_next = last_q ? pfe_pkg::S_EMIT : pfe_pkg::S_IDLE;
      pfe_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = pfe_pkg::S_IDLE;
        end
      end
      default: state_next = pfe_pkg::S_IDLE;
    endcase
  end

  // datapath, stack pointer and memory port
  always_comb begin
    count_next      = count;
    discarding_next = discarding;
    res_value_next  = res_value;
    res_status_next = res_status;
    mem_req         = '0;
    div_start       = 1'b0;
    out_valid_next  = out_valid && out_stall;
    unique case (state)
      pfe_pkg::S_IDLE: begin
        if (accept) begin
          if (discarding) begin
            // skip the rest of a failed expression
            if (last) begin
              discarding_next = 1'b0;
              count_next      = '0;
            end
          end else if (is_digit) begin
            if (stack_full) begin
              res_value_next  = '0;
              res_status_next = pfe_pkg::ST_OVERFLOW;
              if (last) begin
                count_next = '0;
              end else begin
                discarding_next = 1'b1;
              end
            end else begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = count[pfe_pkg::PTR_W-1:0];
              mem_req.wr_data = {24'b0, digit_val};
              if (last) begin
                // the pushed digit is the top, pop it right away
                res_value_next  = {24'b0, digit_val};
                res_status_next = pfe_pkg::ST_OK;
                count_next      = '0;
              end else begin
                count_next = count + 1'b1;
              end
            end
          end else if (stack_short || !is_op) begin
            res_value_next  = '0;
            res_status_next = stack_short ? pfe_pkg::ST_UNDERFLOW : pfe_pkg::ST_INVALID;
            if (last) begin
              count_next = '0;
            end else begin
              discarding_next = 1'b1;
            end
          end else begin
            // fetch the second operand from the top
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = pfe_pkg::PTR_W'(count - 1'b1);
          end
        end
      end
      pfe_pkg::S_RD_A: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = pfe_pkg::PTR_W'(count - 2'd2);
      end
      pfe_pkg::S_EXEC: begin
        // first operand arrives on rd_data here
        unique case (sym_q)
          pfe_pkg::CH_PLUS:  res_value_next = rd_data + opb;
          pfe_pkg::CH_MINUS: res_value_next = rd_data - opb;
          pfe_pkg::CH_STAR:  res_value_next = rd_data * opb;
          pfe_pkg::CH_SLASH: begin
            if (opb == '0) begin
              res_value_next  = '0;
              res_status_next = pfe_pkg::ST_DIVZERO;
              if (last_q) begin
                count_next = '0;
              end else begin
                discarding_next = 1'b1;
              end
            end else begin
              div_start = 1'b1;
            end
          end
          default: res_value_next = res_value;
        endcase
      end
      pfe_pkg::S_DIV: begin
        if (div_done) begin
          res_value_next = div_quotient;
        end
      end
      pfe_pkg::S_WB: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pfe_pkg::PTR_W'(count - 2'd2);
        mem_req.wr_data = res_value;
        if (last_q) begin
          res_status_next = pfe_pkg::ST_OK;
          count_next      = '0;
        end else begin
          count_next = count - 1'b1;
        end
      end
      pfe_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pfe_pkg::S_IDLE;
      count      <= '0;
      discarding <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      discarding <= discarding_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_value  <= res_value_next;
    res_status <= res_status_next;
    if (accept) begin
      sym_q  <= symbol;
      last_q <= last;
    end
    if (state == pfe_pkg::S_RD_A) begin
      opb <= rd_data;
    end
    if ((state == pfe_pkg::S_EMIT) && out_free) begin
      value  <= res_value;
      status <= res_status;
    end
  end

  // the stack memory never sees a read and a write in one cycle
  a_mem_excl: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.wr_en && mem_req.rd_en))
    else $error("stack memory read and write in one cycle");

  // stack count stays within the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  // a write back always has two operands below it
  a_wb_operands: assert property (@(posedge clk) disable iff (rst)
    (state == pfe_pkg::S_WB) |-> (count >= pfe_pkg::CNT_W'(2)))
    else $error("write back with short stack");

  // the divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == pfe_pkg::S_DIV))
    else $error("divider done outside divide wait");

  // a divide start leads into the divide wait
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == pfe_pkg::S_DIV))
    else $error("divide started without wait state");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the postfix expression evaluator: a table of
// directed expressions, then random expressions scored by a behavioral
// predictor, with random idling and a long output hold-off
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES  = 400;   // long output hold-off
  localparam int TAIL_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 500000;

  // one expected output transfer
  typedef struct {
    logic [31:0] value;
    logic [2:0]  status;
  } result_t;

  // one input transfer
  typedef struct {
    logic [7:0] sym;
    logic       lst;
  } char_t;

  // one directed expression; fixed rows carry their result by hand
  typedef struct {
    string       text;
    bit          fixed;
    logic [31:0] value;
    logic [2:0]  status;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  symbol = '0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [31:0] value;
  logic [2:0]  status;

  // predictor state
  logic [31:0] model_stack [pfe_pkg::STACK_DEPTH];
  int          model_depth = 0;
  bit          model_skipping = 1'b0;

  result_t     expected_results[$];
  char_t       expr_chars[$];
  int          items_sent = 0;
  int          failures = 0;
  int          cycle_count = 0;
  int          tx_gap_max = 12;
  int          rx_gap_max = 12;
  bit          rx_hold_req = 1'b0;

  logic [7:0]  op_codes [4] = '{pfe_pkg::CH_PLUS, pfe_pkg::CH_MINUS,
                                pfe_pkg::CH_STAR, pfe_pkg::CH_SLASH};

  postfix_expression_evaluator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .symbol    (symbol),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

  always #5 clk = ~clk;

  // run guard: a hung handshake ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("postfix_expression_evaluator test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor: carries out one accepted character on the private stack copy
  // ---------------------------------------------------------------------------
  function automatic void evaluate_symbol(input logic [7:0] sym, input logic lst,
                                          output bit produced, output logic [31:0] val,
                                          output logic [2:0] st);
    logic [31:0] lhs, rhs, res, mag_l, mag_r, quo;
    produced = 1'b0;
    val = '0;
    st = pfe_pkg::ST_OK;
    res = '0;
    // a failed expression is skipped up to its final character, silently
    if (model_skipping) begin
      if (lst) begin
        model_skipping = 1'b0;
        model_depth = 0;
      end
      return;
    end
    if (sym >= pfe_pkg::CH_ZERO && sym <= pfe_pkg::CH_NINE) begin
      if (model_depth >= pfe_pkg::STACK_DEPTH) begin
        st = pfe_pkg::ST_OVERFLOW;
      end else begin
        model_stack[model_depth] = {24'd0, sym - pfe_pkg::CH_ZERO};
        model_depth++;
      end
    end else if (model_depth < 2) begin
      // short stack wins over character classification
      st = pfe_pkg::ST_UNDERFLOW;
    end else begin
      rhs = model_stack[model_depth-1];
      lhs = model_stack[model_depth-2];
      case (sym)
        pfe_pkg::CH_PLUS:  res = lhs + rhs;
        pfe_pkg::CH_MINUS: res = lhs - rhs;
        pfe_pkg::CH_STAR:  res = lhs * rhs;
        pfe_pkg::CH_SLASH: begin
          if (rhs == '0) begin
            st = pfe_pkg::ST_DIVZERO;
          end else begin
            // truncate toward zero on magnitudes; min / -1 wraps to min
            mag_l = lhs[31] ? -lhs : lhs;
            mag_r = rhs[31] ? -rhs : rhs;
            quo = mag_l / mag_r;
            res = (lhs[31] ^ rhs[31]) ? -quo : quo;
          end
        end
        default:  st = pfe_pkg::ST_INVALID;
      endcase
      if (st == pfe_pkg::ST_OK) begin
        model_depth--;
        model_stack[model_depth-1] = res;
      end
    end
    // final character pops the top; anything below it is dropped
    if (st == pfe_pkg::ST_OK && lst) begin
      if (model_depth == 0) begin
        st = pfe_pkg::ST_UNDERFLOW;
      end else begin
        model_depth--;
        val = model_stack[model_depth];
      end
    end
    if (st != pfe_pkg::ST_OK) begin
      produced = 1'b1;
      val = '0;
      if (lst) model_depth = 0;
      else model_skipping = 1'b1;
    end else if (lst) begin
      produced = 1'b1;
      model_depth = 0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    failures++;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stall per result, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = $urandom_range(0, rx_gap_max);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // result checker: every output transfer against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none outstanding", value, '0);
      end else begin
        want = expected_results.pop_front();
        if (value !== want.value) report_mismatch("value", value, want.value);
        if (status !== want.status) report_mismatch("status", {29'd0, status},
                                                    {29'd0, want.status});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offers one character after a random gap and returns at its transfer edge
  task automatic offer_symbol(input logic [7:0] sym, input logic lst);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol <= sym;
    last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sends expr_chars; fixed rows replace the predicted result by their own
  task automatic run_expression(input bit use_fixed, input result_t fixed);
    bit          produced;
    logic [31:0] val;
    logic [2:0]  st;
    result_t     r;
    foreach (expr_chars[i]) begin
      offer_symbol(expr_chars[i].sym, expr_chars[i].lst);
      evaluate_symbol(expr_chars[i].sym, expr_chars[i].lst, produced, val, st);
      if (produced) begin
        if (use_fixed) begin
          r = fixed;
        end else begin
          r.value = val;
          r.status = st;
        end
        expected_results.push_back(r);
      end
    end
    items_sent += expr_chars.size();
  endtask

  // sender stops and waits for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // random expression: mostly well formed, some broken, some pure noise,
  // a few deep enough to come near or run past the stack
  task automatic build_random_expression(input bit deep_only);
    int kind, len, depth, bad_pct, min_digits;
    bit mul_heavy;
    logic [7:0] sym;
    expr_chars.delete();
    kind = deep_only ? 0 : $urandom_range(0, 99);
    bad_pct = 0;
    min_digits = 0;
    mul_heavy = 1'b0;
    len = $urandom_range(1, 16);
    if (kind < 4) begin
      // a deep-only run always pushes past the stack depth
      min_digits = deep_only ? $urandom_range(pfe_pkg::STACK_DEPTH + 1, 70) :
                               $urandom_range(58, 70);
      len = min_digits + $urandom_range(1, 8);
    end else if (kind < 20) begin
      bad_pct = $urandom_range(5, 30);
    end else if (kind < 30) begin
      bad_pct = 100;
      len = $urandom_range(1, 6);
    end else if (kind < 40) begin
      // long products so the 32-bit result can wrap
      mul_heavy = 1'b1;
      len = $urandom_range(12, 30);
    end
    depth = 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < bad_pct) begin
        case ($urandom_range(0, 7))
          0:       sym = 8'h00;
          1:       sym = 8'hFF;
          default: sym = 8'($urandom_range(0, 255));
        endcase
      end else if (i < min_digits || depth < 2 || $urandom_range(0, 1) == 0) begin
        sym = pfe_pkg::CH_ZERO +
              8'(mul_heavy ? $urandom_range(2, 9) : $urandom_range(0, 9));
        depth++;
      end else begin
        sym = mul_heavy ? pfe_pkg::CH_STAR : op_codes[$urandom_range(0, 3)];
        depth--;
      end
      expr_chars.push_back('{sym, i == len - 1});
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed expressions; the final character of each carries last
  // ---------------------------------------------------------------------------
  directed_row_t directed_rows [14] = '{
    '{"9",      1'b1, 32'd9,           pfe_pkg::ST_OK},        // first one after reset
    '{"0",      1'b1, 32'd0,           pfe_pkg::ST_OK},
    '{"94-",    1'b0, 32'd0,           pfe_pkg::ST_OK},
    '{"27-",    1'b0, 32'd0,           pfe_pkg::ST_OK},        // negative result
    '{"23*",    1'b0, 32'd0,           pfe_pkg::ST_OK},
    '{"72/",    1'b0, 32'd0,           pfe_pkg::ST_OK},
    '{"07-3/",  1'b0, 32'd0,           pfe_pkg::ST_OK},        // truncation toward zero
    '{"123+",   1'b0, 32'd0,           pfe_pkg::ST_OK},        // entry left below the top
    // 8^10 * 2 is the most negative word, then divided by -1
    '{"88*8*8*8*8*8*8*8*8*2*12-/", 1'b1, 32'h8000_0000, pfe_pkg::ST_OK},
    '{"50/",    1'b1, 32'd0,           pfe_pkg::ST_DIVZERO},
    '{"+",      1'b1, 32'd0,           pfe_pkg::ST_UNDERFLOW}, // final char, empty stack
    '{"5\377",  1'b1, 32'd0,           pfe_pkg::ST_UNDERFLOW}, // unknown char, short stack
    '{"55\377", 1'b1, 32'd0,           pfe_pkg::ST_INVALID},
    '{"1+23+",  1'b1, 32'd0,           pfe_pkg::ST_UNDERFLOW}  // error mid-way, rest skipped
  };

  initial begin
    result_t fixed;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      expr_chars.delete();
      for (int i = 0; i < directed_rows[r].text.len(); i++)
        expr_chars.push_back('{directed_rows[r].text[i], i == directed_rows[r].text.len() - 1});
      fixed.value = directed_rows[r].value;
      fixed.status = directed_rows[r].status;
      run_expression(directed_rows[r].fixed, fixed);
    end
    fixed = '{default: '0};

    // one guaranteed stack overflow before the random mix
    build_random_expression(1'b1);
    run_expression(1'b0, fixed);
    drain_results();

    // random phases, each with its own idling mix, extremes included
    for (int phase = 0; phase < 4; phase++) begin
      tx_gap_max = (phase == 0 || phase == 3) ? 12 : 0;
      rx_gap_max = (phase == 0 || phase == 2) ? 12 : 0;
      while (items_sent < (phase + 1) * RANDOM_ITEMS / 4) begin
        build_random_expression(1'b0);
        run_expression(1'b0, fixed);
        if ($urandom_range(0, 39) == 0) drain_results();
      end
      drain_results();

      // output held off while input runs flat out, so the block backs up
      if (phase == 1) begin
        rx_hold_req = 1'b1;
        tx_gap_max = 0;
        for (int n = 0; n < 10; n++) begin
          build_random_expression(1'b0);
          run_expression(1'b0, fixed);
        end
        drain_results();
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("postfix_expression_evaluator test passed");
    end else begin
      $display("postfix_expression_evaluator test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pfe_pkg.sv
rtl/pfe_stack_mem.sv
rtl/pfe_divider.sv
rtl/postfix_expression_evaluator.sv
bench/tb.sv
